[design/pss_pkg.sv]
// Package for the phrase step sequencer: widths, codes, reset tables.
// No dependencies.
package pss_pkg;

	localparam int DEF_MAX_STEPS  = 32;
	localparam int DEF_COUNT_WRAP = 10000000;
	localparam int TICK_W = 24;

	typedef enum logic [1:0] {
		ACT_TICK  = 2'd0,
		ACT_STEP  = 2'd1,
		ACT_STAGE = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EDGE,
		ST_SWAP,
		ST_PITCH,
		ST_DIV,
		ST_OUT
	} state_t;

	localparam logic [0:0] CFG_REST  = 1'b0;
	localparam logic [0:0] CFG_GLIDE = 1'b1;

	function automatic logic [6:0] init_note(input int i);
		case (i)
			0: init_note = 7'd60;
			1: init_note = 7'd62;
			2: init_note = 7'd67;
			3: init_note = 7'd65;
			4: init_note = 7'd62;
			5: init_note = 7'd60;
			default: init_note = 7'd0;
		endcase
	endfunction

endpackage

[design/pss_div.sv]
// Restoring divider, one quotient bit per cycle: q = num / den.
// Depends on nothing.
module pss_div #(
	parameter int NW = 48,
	parameter int DW = 40
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo
);
	localparam int CW = $clog2(NW + 1);
	logic [NW-1:0] n_q;
	logic [DW:0]   r_q;
	logic [DW-1:0] d_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [DW:0]   sh;
	logic          ge;

	assign sh = {r_q[DW-1:0], n_q[NW-1]};
	assign ge = sh >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			d_q <= den;
			r_q <= '0;
		end else if (busy_q) begin
			r_q <= ge ? sh - {1'b0, d_q} : sh;
			n_q <= {n_q[NW-2:0], ge};
		end
	end

	assign quo = n_q;
endmodule

[design/phrase_step_sequencer_unit.sv]
// Top level of the phrase step sequencer: banks, step sequencer, glide.
// Depends on pss_pkg and pss_div.
//
// channel | dir | handshake         | payload
// in      | in  | in_valid/in_ready | action, clock_level, step_*, staged_*
// out     | out | out_valid/out_ready | pitch_q8, gate, accent, phrase_*
// cfg     | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// A load word passes the edge state back to idle. A tick passes the edge state,
// the swap state on a clock edge, the pitch state, the divider state for a glide
// and the output state; a phrase end with a staged bank stays in swap to copy it.
// Reset restores the power-up phrase in flops at once; no clearing pass.
// in_ready is low while a word is worked on; results sit in an output
// register, so a waiting result only holds the block in its output state.
module phrase_step_sequencer_unit #(
	parameter int MAX_STEPS  = pss_pkg::DEF_MAX_STEPS,
	parameter int COUNT_WRAP = pss_pkg::DEF_COUNT_WRAP
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic        clock_level,
	input  logic [4:0]  step_slot,
	input  logic [6:0]  step_note,
	input  logic [1:0]  step_duration,
	input  logic        step_accent,
	input  logic        step_glide,
	input  logic [5:0]  staged_length,
	input  logic [7:0]  staged_gap,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [14:0] pitch_q8,
	output logic        gate,
	output logic        accent,
	output logic        phrase_start,
	output logic        phrase_new,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);
	localparam int IW = $clog2(MAX_STEPS);
	localparam int LW = $clog2(MAX_STEPS + 1);
	localparam int TW = pss_pkg::TICK_W;

	// play bank in flops (reset value); staged bank as a memory
	logic [6:0] pn_q [MAX_STEPS];
	logic [1:0] pd_q [MAX_STEPS];
	logic       pa_q [MAX_STEPS];
	logic       pg_q [MAX_STEPS];
	logic [10:0] stg_mem [MAX_STEPS];
	logic [10:0] stg_rd_q;

	logic [3:0]  rest_clocks_q;
	logic [15:0] glide_max_q;
	logic [LW-1:0] play_len_q, stg_len_q;
	logic [7:0]  play_gap_q, stg_gap_q;
	logic        stg_valid_q;
	logic [LW-1:0] step_idx_q;
	logic [1:0]  cis_q;
	logic [3:0]  rest_q;
	logic [TW-1:0] tse_q, period_q;
	logic        clk_prev_q;
	logic [14:0] held_q;
	logic        start_q, new_q;

	pss_pkg::state_t st_q, st_d;
	logic [IW-1:0] cpy_q;
	logic        clk_lv_q;
	logic [1:0]  act_q;
	logic [4:0]  wslot_q;
	logic [10:0] wdata_q;
	logic [5:0]  slen_q;
	logic [7:0]  sgap_q;
	logic        gate_q, acc_q;
	logic [14:0] pitch_o_q;
	logic        start_o_q, new_o_q;
	logic        ovalid_q;
	logic        out_load;
	logic        neg_q;
	logic [14:0] prev_q;

	// current and previous step
	logic [IW-1:0] idx, pidx;
	logic [1:0]  lastc;
	logic [31:0] thr;
	logic [39:0] g_cap, g_sel;
	logic [31:0] t256;
	logic [14:0] tgt, prv, note_span;
	logic        div_start, div_done;
	logic [47:0] div_num, div_quo;
	logic [39:0] div_den;

	assign idx = (step_idx_q < LW'(MAX_STEPS)) ? step_idx_q[IW-1:0] : '0;
	always_comb begin
		if (idx == '0)
			pidx = (play_len_q > 0) ? IW'(play_len_q - 1'b1) : '0;
		else
			pidx = idx - 1'b1;
	end
	assign lastc = (pd_q[idx] == 2'd0) ? 2'd0 : pd_q[idx] - 2'd1;
	assign thr   = {8'd0, period_q} * {24'd0, play_gap_q};
	assign g_cap = {16'd0, glide_max_q, 8'd0};
	assign g_sel = ({8'd0, thr} > g_cap) ? g_cap : {8'd0, thr};
	assign t256  = {tse_q, 8'd0};
	assign tgt   = {pn_q[idx], 8'd0};
	assign prv   = {pn_q[pidx], 8'd0};
	assign note_span = (tgt >= prv) ? tgt - prv : prv - tgt;
	assign div_num = 48'(note_span) * 48'(t256);
	assign div_den = g_sel;
	assign div_start = (st_q == pss_pkg::ST_PITCH) && pg_q[idx] && cis_q == 2'd0
		&& g_sel != 0 && {8'd0, t256} < g_sel;

	pss_div #(.NW(48), .DW(40)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(div_den),
		.done(div_done), .quo(div_quo)
	);

	// output register free, or its word leaves this cycle
	assign out_load  = !ovalid_q || out_ready;
	assign in_ready  = (st_q == pss_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = ovalid_q;
	assign pitch_q8 = pitch_o_q;
	assign gate = gate_q;
	assign accent = acc_q;
	assign phrase_start = start_o_q;
	assign phrase_new = new_o_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= pss_pkg::ST_IDLE;
		else st_q <= st_d;
	end

	logic wrap;
	assign wrap = step_idx_q >= play_len_q;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			pss_pkg::ST_IDLE:  if (in_valid && in_ready) st_d = pss_pkg::ST_EDGE;
			pss_pkg::ST_EDGE: begin
				if (act_q != pss_pkg::ACT_TICK) st_d = pss_pkg::ST_IDLE;
				else if (clk_lv_q && !clk_prev_q) st_d = pss_pkg::ST_SWAP;
				else st_d = pss_pkg::ST_PITCH;
			end
			pss_pkg::ST_SWAP: begin
				if (!(wrap && stg_valid_q) || cpy_q == IW'(MAX_STEPS - 1))
					st_d = pss_pkg::ST_PITCH;
			end
			pss_pkg::ST_PITCH: st_d = div_start ? pss_pkg::ST_DIV : pss_pkg::ST_OUT;
			pss_pkg::ST_DIV:   if (div_done) st_d = pss_pkg::ST_OUT;
			pss_pkg::ST_OUT:   if (out_load) st_d = pss_pkg::ST_IDLE;
			default: st_d = pss_pkg::ST_IDLE;
		endcase
	end

	// staged memory: write after capture, read during the copy sweep
	always_ff @(posedge clk) begin
		if (st_q == pss_pkg::ST_EDGE && act_q == pss_pkg::ACT_STEP
			&& 7'(wslot_q) < 7'(MAX_STEPS))
			stg_mem[IW'(wslot_q)] <= wdata_q;
		stg_rd_q <= stg_mem[(st_q == pss_pkg::ST_SWAP) ? cpy_q + 1'b1 : '0];
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			act_q    <= action;
			clk_lv_q <= clock_level;
			wslot_q  <= step_slot;
			wdata_q  <= {step_note, step_duration, step_accent, step_glide};
			slen_q   <= staged_length;
			sgap_q   <= staged_gap;
		end
		if (st_q == pss_pkg::ST_PITCH) neg_q <= tgt < prv;
		if (st_q == pss_pkg::ST_PITCH) prev_q <= prv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_STEPS; i++) begin
				pn_q[i] <= pss_pkg::init_note(i);
				pd_q[i] <= (i < 6) ? 2'd2 : 2'd0;
				pa_q[i] <= 1'b0;
				pg_q[i] <= 1'b0;
			end
			rest_clocks_q <= 4'd2;
			glide_max_q <= 16'd2880;
			play_len_q <= (MAX_STEPS < 6) ? LW'(MAX_STEPS) : LW'(6);
			play_gap_q <= 8'd223;
			stg_len_q <= LW'(6);
			stg_gap_q <= 8'd223;
			stg_valid_q <= 1'b0;
			step_idx_q <= '0;
			cis_q <= '0;
			rest_q <= '0;
			tse_q <= '0;
			period_q <= '0;
			clk_prev_q <= 1'b0;
			held_q <= '0;
			start_q <= 1'b0;
			new_q <= 1'b0;
			cpy_q <= '0;
			gate_q <= 1'b0;
			acc_q <= 1'b0;
			pitch_o_q <= '0;
			start_o_q <= 1'b0;
			new_o_q <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (st_q == pss_pkg::ST_OUT && out_load) ovalid_q <= 1'b1;
			else if (out_ready) ovalid_q <= 1'b0;
			if (cfg_valid) begin
				if (cfg_index == pss_pkg::CFG_REST) rest_clocks_q <= cfg_data[3:0];
				else glide_max_q <= cfg_data;
			end
			unique case (st_q)
				pss_pkg::ST_EDGE: begin
					cpy_q <= '0;
					if (act_q == pss_pkg::ACT_STAGE) begin
						if (slen_q < 6'd4) stg_len_q <= LW'(4);
						else if (7'(slen_q) > 7'(MAX_STEPS))
							stg_len_q <= LW'(MAX_STEPS);
						else stg_len_q <= LW'(slen_q);
						stg_gap_q <= sgap_q;
						stg_valid_q <= 1'b1;
					end else if (act_q == pss_pkg::ACT_TICK) begin
						clk_prev_q <= clk_lv_q;
						if (clk_lv_q && !clk_prev_q) begin
							if (rest_q == 0) begin
								if (cis_q >= lastc) begin
									cis_q <= '0;
									step_idx_q <= step_idx_q + 1'b1;
								end else cis_q <= cis_q + 1'b1;
							end else rest_q <= rest_q - 1'b1;
							period_q <= tse_q;
							tse_q <= '0;
						end else if (tse_q >= TW'(COUNT_WRAP)) tse_q <= '0;
						else tse_q <= tse_q + 1'b1;
					end
				end
				pss_pkg::ST_SWAP: begin
					// wrap handling; bank copy sweeps one step a cycle
					start_q <= wrap;
					new_q <= wrap && stg_valid_q;
					if (wrap && stg_valid_q) begin
						{pn_q[cpy_q], pd_q[cpy_q], pa_q[cpy_q], pg_q[cpy_q]} <= stg_rd_q;
						cpy_q <= cpy_q + 1'b1;
						if (cpy_q == IW'(MAX_STEPS - 1)) begin
							step_idx_q <= '0;
							play_len_q <= stg_len_q;
							play_gap_q <= stg_gap_q;
							if (rest_clocks_q != 0) rest_q <= rest_clocks_q;
						end
					end else if (wrap) begin
						step_idx_q <= '0;
						if (rest_clocks_q != 0) rest_q <= rest_clocks_q;
					end
				end
				pss_pkg::ST_PITCH: begin
					if (!pg_q[idx] || cis_q != 0) begin
						if (rest_q == 0) held_q <= tgt;
					end else if (!div_start) held_q <= tgt;
				end
				pss_pkg::ST_DIV: begin
					if (div_done)
						held_q <= neg_q ? prev_q - div_quo[14:0] : prev_q + div_quo[14:0];
				end
				pss_pkg::ST_OUT: begin
					// wait here until the output register is free
					if (out_load) begin
						pitch_o_q <= held_q;
						gate_q <= !(rest_q != 0 ||
							({8'd0, t256} > {8'd0, thr} && cis_q >= lastc));
						acc_q <= pa_q[idx];
						start_o_q <= start_q;
						new_o_q <= new_q;
					end
				end
				default: ;
			endcase
		end
	end

	// the divider only finishes inside the glide state
	a_div_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> st_q == pss_pkg::ST_DIV)
		else $error("divider finished outside glide state");
	// a waiting result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pitch_q8) && $stable(gate))
		else $error("result changed while waiting");
	// a result only follows the output state
	a_out_from_state: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(st_q) == pss_pkg::ST_OUT)
		else $error("result raised outside output state");
endmodule

[tb/phrase_step_sequencer_unit_test.sv]
// Testbench for phrase_step_sequencer_unit: random and directed load and tick words,
// an in-bench phrase player that predicts each tick result, and a field-by-field check.
// Depends on pss_pkg and the design files.
module phrase_step_sequencer_unit_test;

	localparam int STEPS     = pss_pkg::DEF_MAX_STEPS;
	localparam int WD_LIMIT  = 20000;  // cycles with no handshake on any channel
	localparam int SETTLE    = 150;    // covers a slow glide tick plus a bank copy

	typedef struct {
		pss_pkg::action_t act;
		logic       lvl;
		logic [4:0] slot;
		logic [6:0] note;
		logic [1:0] dur;
		logic       acc;
		logic       gl;
		logic [5:0] len;
		logic [7:0] gap;
	} word_t;

	typedef struct {
		logic [14:0] pitch;
		logic        gate;
		logic        accent;
		logic        start;
		logic        fresh;
	} tick_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0, in_ready;
	logic [1:0] action = 2'd0;
	logic clock_level = 1'b0;
	logic [4:0] step_slot = '0;
	logic [6:0] step_note = '0;
	logic [1:0] step_duration = '0;
	logic step_accent = 1'b0, step_glide = 1'b0;
	logic [5:0] staged_length = '0;
	logic [7:0] staged_gap = '0;
	logic out_valid, out_ready = 1'b0;
	logic [14:0] pitch_q8;
	logic gate, accent, phrase_start, phrase_new;
	logic cfg_valid = 1'b0, cfg_ready;
	logic cfg_index = pss_pkg::CFG_REST;
	logic [15:0] cfg_data = '0;

	phrase_step_sequencer_unit DUT (.*);

	always #10 clk = ~clk;

	// ---- in-bench phrase player ----
	logic [6:0] pl_note[STEPS], sg_note[STEPS];
	logic [1:0] pl_dur[STEPS], sg_dur[STEPS];
	logic       pl_acc[STEPS], sg_acc[STEPS];
	logic       pl_gl[STEPS], sg_gl[STEPS];
	int unsigned pl_len, pl_gap, sg_len, sg_gap;
	bit sg_ok;
	int unsigned step_ix, clk_in_step, rest_cnt, tick_cnt, period;
	bit lvl_prev, start_flag, new_flag;
	int unsigned held;
	int unsigned rest_set = 2, glide_cap = 2880;

	word_t     pending[$];
	tick_out_t tick_due[$];
	word_t     cur_word;
	int unsigned send_idle = 0, recv_stall = 0;
	int errors = 0;
	logic in_fire = 1'b0;

	function automatic int unsigned last_clock(int unsigned i);
		return pl_dur[i] == 0 ? 0 : pl_dur[i] - 1;
	endfunction

	function automatic void clock_edge();
		bit st, nw;
		st = 0;
		nw = 0;
		if (rest_cnt == 0) begin
			if (clk_in_step >= last_clock(step_ix)) begin
				clk_in_step = 0;
				step_ix++;
			end else begin
				clk_in_step++;
			end
		end else begin
			rest_cnt--;
		end
		if (step_ix >= pl_len) begin
			st = 1;
			step_ix = 0;
			if (sg_ok) begin
				// staged bank replaces the playing one wholesale
				nw = 1;
				pl_note = sg_note;
				pl_dur = sg_dur;
				pl_acc = sg_acc;
				pl_gl = sg_gl;
				pl_len = sg_len;
				pl_gap = sg_gap;
			end
			if (rest_set > 0) rest_cnt = rest_set;
		end
		period = tick_cnt;
		tick_cnt = 0;
		start_flag = st;
		new_flag = nw;
	endfunction

	function automatic void apply_word(word_t w);
		int unsigned ix, pi, tgt, prv;
		longint unsigned thr, g, cap, t;
		tick_out_t r;
		case (w.act)
			pss_pkg::ACT_STEP: begin
				sg_note[w.slot] = w.note;
				sg_dur[w.slot] = w.dur;
				sg_acc[w.slot] = w.acc;
				sg_gl[w.slot] = w.gl;
			end
			pss_pkg::ACT_STAGE: begin
				sg_len = w.len < 4 ? 4 : (w.len > STEPS ? STEPS : w.len);
				sg_gap = w.gap;
				sg_ok = 1;
			end
			pss_pkg::ACT_TICK: begin
				if (w.lvl && !lvl_prev) clock_edge();
				else begin
					tick_cnt++;
					if (tick_cnt > pss_pkg::DEF_COUNT_WRAP) tick_cnt = 0;
				end
				lvl_prev = w.lvl;
				ix = step_ix < STEPS ? step_ix : 0;
				tgt = pl_note[ix] * 256;
				thr = longint'(period) * pl_gap;
				if (!pl_gl[ix] || clk_in_step > 0) begin
					if (rest_cnt == 0) held = tgt;
				end else begin
					// linear glide from the previous step's note
					pi = ix == 0 ? (pl_len > 0 ? pl_len - 1 : 0) : ix - 1;
					if (pi >= STEPS) pi = STEPS - 1;
					prv = pl_note[pi] * 256;
					cap = longint'(glide_cap) * 256;
					g = thr > cap ? cap : thr;
					t = longint'(tick_cnt) * 256;
					if (g == 0 || t >= g) held = tgt;
					else if (tgt >= prv) held = prv + ((longint'(tgt - prv) * t) / g);
					else held = prv - ((longint'(prv - tgt) * t) / g);
				end
				r.pitch = held[14:0];
				r.gate = !(rest_cnt > 0 ||
					(longint'(tick_cnt) * 256 > thr && clk_in_step >= last_clock(ix)));
				r.accent = pl_acc[ix];
				r.start = start_flag;
				r.fresh = new_flag;
				tick_due.insert(tick_due.size(), r);
			end
			default: ;  // unused code is dropped
		endcase
	endfunction

	initial begin
		for (int i = 0; i < STEPS; i++) begin
			pl_note[i] = pss_pkg::init_note(i);
			pl_dur[i] = i < 6 ? 2'd2 : 2'd0;
			pl_acc[i] = 0;
			pl_gl[i] = 0;
		end
		pl_len = 6; pl_gap = 223; sg_len = 6; sg_gap = 223; sg_ok = 0;
		step_ix = 0; clk_in_step = 0; rest_cnt = 0; tick_cnt = 0; period = 0;
		lvl_prev = 0; held = 0; start_flag = 0; new_flag = 0;
	end

	// ---- driver: new word on the falling edge once the last one went ----
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_fire) begin
			if (pending.size() > 0 && $urandom_range(99) >= send_idle) begin
				cur_word = pending.pop_front();
				in_valid <= 1'b1;
				action <= cur_word.act;
				clock_level <= cur_word.lvl;
				step_slot <= cur_word.slot;
				step_note <= cur_word.note;
				step_duration <= cur_word.dur;
				step_accent <= cur_word.acc;
				step_glide <= cur_word.gl;
				staged_length <= cur_word.len;
				staged_gap <= cur_word.gap;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_ready <= $urandom_range(99) >= recv_stall;
	end

	// ---- monitor: accept on the rising edge, compare with the oldest tick due ----
	always @(posedge clk) begin
		tick_out_t e;
		in_fire <= in_valid && in_ready;
		if (in_valid && in_ready) apply_word(cur_word);
		if (out_valid && out_ready) begin
			if (tick_due.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
			end else begin
				e = tick_due.pop_front();
				if (pitch_q8 !== e.pitch) begin
					$error("pitch_q8: expected %0d got %0d", e.pitch, pitch_q8); errors++;
				end
				if (gate !== e.gate) begin
					$error("gate: expected %0d got %0d", e.gate, gate); errors++;
				end
				if (accent !== e.accent) begin
					$error("accent: expected %0d got %0d", e.accent, accent); errors++;
				end
				if (phrase_start !== e.start) begin
					$error("phrase_start: expected %0d got %0d", e.start, phrase_start);
					errors++;
				end
				if (phrase_new !== e.fresh) begin
					$error("phrase_new: expected %0d got %0d", e.fresh, phrase_new); errors++;
				end
			end
		end
	end

	// ---- watchdog ----
	int unsigned quiet = 0;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WD_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// ---- stimulus helpers ----
	int unsigned lvl_run = 0;
	logic lvl_now = 1'b0;
	int unsigned words_made = 0;

	task automatic push(word_t w);
		pending.insert(pending.size(), w);
		words_made++;
	endtask

	function automatic word_t blank_word(pss_pkg::action_t a);
		word_t w;
		w.act = a;
		w.lvl = $urandom_range(1);
		w.slot = $urandom_range(31);
		w.note = $urandom_range(127);
		w.dur = $urandom_range(3);
		w.acc = $urandom_range(1);
		w.gl = $urandom_range(1);
		w.len = $urandom_range(63);
		w.gap = $urandom_range(255);
		return w;
	endfunction

	// clock waveform sampled per tick, random level run lengths
	task automatic add_ticks(int n, int max_run);
		word_t w;
		repeat (n) begin
			if (lvl_run == 0) begin
				lvl_now = ~lvl_now;
				lvl_run = $urandom_range(max_run, 1);
			end
			lvl_run--;
			w = blank_word(pss_pkg::ACT_TICK);
			w.lvl = lvl_now;
			push(w);
		end
	endtask

	task automatic add_step(int s, int nt, int d, bit a, bit g);
		word_t w;
		w = blank_word(pss_pkg::ACT_STEP);
		w.slot = s; w.note = nt; w.dur = d; w.acc = a; w.gl = g;
		push(w);
	endtask

	task automatic add_stage(int l, int gp);
		word_t w;
		w = blank_word(pss_pkg::ACT_STAGE);
		w.len = l; w.gap = gp;
		push(w);
	endtask

	task automatic drain();
		wait (pending.size() == 0 && !in_valid);
		wait (tick_due.size() == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == pss_pkg::CFG_REST) rest_set = val[3:0];
		else glide_cap = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_phase(int target);
		int stop;
		stop = words_made + target;
		while (words_made < stop) begin
			case ($urandom_range(19))
				0, 1: add_step($urandom_range(31), $urandom_range(127),
					$urandom_range(3, 1), $urandom_range(1), $urandom_range(1));
				2: add_stage($urandom_range(3) == 0 ? $urandom_range(63) : $urandom_range(8, 4),
					$urandom_range(3) == 0 ? $urandom_range(255) : $urandom_range(253, 102));
				3: push(blank_word(pss_pkg::ACT_NONE));   // noise, ignored
				4: add_ticks(8, 40);             // slow clock, long glides
				default: add_ticks(8, 3);
			endcase
		end
	endtask

	// ---- main sequence ----
	initial begin
		// whole staged bank written first so no unwritten entry is ever copied in
		for (int i = 0; i < STEPS; i++)
			add_step(i, $urandom_range(127), $urandom_range(3, 1), $urandom_range(1),
				$urandom_range(1));
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: power-up phrase, field extremes, odd codes, saturation
		add_ticks(40, 2);
		push(blank_word(pss_pkg::ACT_NONE));
		add_step(0, 127, 0, 1, 1);     // zero duration behaves as one clock
		add_step(1, 0, 3, 0, 1);       // glide down from the top note
		add_step(2, 127, 1, 1, 1);     // glide up
		add_step(31, 0, 0, 0, 0);
		add_stage(0, 0);               // length saturates low, zero gap
		add_ticks(60, 2);
		add_stage(63, 255);            // length saturates high
		add_ticks(80, 1);
		add_stage(4, 102);
		add_ticks(60, 30);
		drain();

		write_reg(pss_pkg::CFG_REST, 16'd0);
		write_reg(pss_pkg::CFG_GLIDE, 16'd0);   // zero glide time
		send_idle = 0; recv_stall = 0;
		random_phase(140);
		drain();

		write_reg(pss_pkg::CFG_REST, 16'hFFFF); // above ten, used as given
		write_reg(pss_pkg::CFG_GLIDE, 16'hFFFF);
		send_idle = 75; recv_stall = 0;
		random_phase(140);
		drain();

		write_reg(pss_pkg::CFG_REST, 16'd10);
		write_reg(pss_pkg::CFG_GLIDE, 16'd3);   // cap below period times gap
		send_idle = 0; recv_stall = 75;
		random_phase(140);
		drain();

		write_reg(pss_pkg::CFG_REST, 16'd2);
		write_reg(pss_pkg::CFG_GLIDE, 16'd2880);
		send_idle = 32; recv_stall = 32;
		random_phase(140);
		drain();

		if (errors == 0 && tick_due.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
